@@ hdl/emt_pkg.sv @@
package emt_pkg;

    // Field and datapath widths
    localparam int DATA_W     = 32;
    localparam int N_ENT      = 9;
    localparam int SQ_W       = 64;   // square / column sum of squares
    localparam int NORM_W     = 32;   // column norm, Q8.24
    localparam int REM_W      = 63;   // divider remainder
    localparam int Q_W        = 31;   // sine quotient, Q1.30
    localparam int T_W        = 62;   // 1 - q^2 in Q2.60
    localparam int C_W        = 31;   // cosine, Q1.30
    localparam int MAG_W      = 64;   // vectoring operand magnitude
    localparam int A_W        = 44;   // CORDIC x/y
    localparam int Z_W        = 34;   // CORDIC angle accumulator
    localparam int LANES      = 3;    // asin, X, Z
    localparam int NORM_STEPS = 6;    // 32,16,8,4,2,1
    localparam int NORM_LO    = 39;   // operands are brought into [2^39, 2^40)

    localparam int CORDIC_STEPS_DEF = 28;

    // Register file
    localparam int MINN_W = 25;
    localparam int GM_W   = 29;
    localparam int ADDR_W = 3;
    localparam logic REG_MIN_NORM = 1'b0;
    localparam logic REG_GIMBAL   = 1'b1;
    localparam logic [MINN_W-1:0] MIN_NORM_RST = 25'd1;
    localparam logic [GM_W-1:0]   GIMBAL_RST   = 29'd3;

    // Angles, Q3.28
    localparam logic signed [Z_W-1:0] FX_PI      = 34'sd843314857;
    localparam logic signed [Z_W-1:0] FX_HALF_PI = 34'sd421657428;

    typedef struct packed {
        logic [N_ENT-1:0]             neg;
        logic [N_ENT-1:0][DATA_W-1:0] mag;
    } side_a_t;

    typedef struct packed {
        logic              degen;
        logic [N_ENT-1:0]  neg;
        logic [DATA_W-1:0] mag0;
        logic [DATA_W-1:0] mag1;
        logic [DATA_W-1:0] mag3;
        logic [DATA_W-1:0] mag4;
        logic [MAG_W-1:0]  p7;
        logic [MAG_W-1:0]  p8;
    } side_b_t;

    typedef struct packed {
        side_b_t        b;
        logic [Q_W-1:0] q;
    } side_c_t;

    typedef struct packed {
        logic             degen;
        logic             gimbal;
        logic [LANES-1:0] num_neg;
        logic [LANES-1:0] den_neg;
        logic [LANES-1:0] den_zero;
    } side_d_t;

    typedef struct packed {
        logic degen;
        logic gimbal;
    } side_e_t;

    // atan(2^-i), rounded Q3.28
    function automatic logic signed [Z_W-1:0] atan_q28(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 34'sd210828714;
            1:  v = 34'sd124459457;
            2:  v = 34'sd65760959;
            3:  v = 34'sd33381290;
            4:  v = 34'sd16755422;
            5:  v = 34'sd8385879;
            6:  v = 34'sd4193963;
            7:  v = 34'sd2097109;
            8:  v = 34'sd1048571;
            9:  v = 34'sd524287;
            10: v = 34'sd262144;
            11: v = 34'sd131072;
            12: v = 34'sd65536;
            13: v = 34'sd32768;
            14: v = 34'sd16384;
            15: v = 34'sd8192;
            16: v = 34'sd4096;
            17: v = 34'sd2048;
            18: v = 34'sd1024;
            19: v = 34'sd512;
            20: v = 34'sd256;
            21: v = 34'sd128;
            22: v = 34'sd64;
            23: v = 34'sd32;
            24: v = 34'sd16;
            25: v = 34'sd8;
            26: v = 34'sd4;
            27: v = 34'sd2;
            28: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/matrix_to_euler_angles_unit.sv @@
// Channel   Dir  Payload                                   Handshake
// s_        in   tdata: m_r0c0..m_r2c2, 9 x 32 bit Q8.24    s_tvalid / s_tready
// m_        out  tdata: angle_x, angle_y, angle_z (Q3.28)   m_tvalid / m_tready
//                tuser: decomp_ok
// cfg       in   APB, reg 0 min_column_norm, reg 4 gimbal   psel / penable, pready = 1
//
// One beat is accepted per cycle while s_tready is high. The pipe is built
// around the three bit-serial chains (column norm root, sine divide, cosine
// root) and the CORDIC chain.
// Reset is synchronous, active low; it clears the valid flags and the config registers.
// A stalled output fills a two-entry output stage; the whole pipe then holds
// and s_tready drops until the skid entry drains.
module matrix_to_euler_angles_unit
    import emt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // m_r0c0 [31:0], m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2 [287:256]
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [N_ENT*DATA_W-1:0]  s_tdata,
    // angle_x [31:0], angle_y [63:32], angle_z [95:64]
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [3*DATA_W-1:0]      m_tdata,
    // decomp_ok [0]
    output logic [0:0]               m_tuser,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // ---------------------------------------------------------------- config
    logic [MINN_W-1:0] min_norm_reg;
    logic [GM_W-1:0]   gimbal_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_norm_reg <= MIN_NORM_RST;
            gimbal_reg   <= GIMBAL_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MIN_NORM: min_norm_reg <= pwdata[MINN_W-1:0];
                REG_GIMBAL:   gimbal_reg   <= pwdata[GM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_NORM: prdata = 32'(min_norm_reg);
            REG_GIMBAL:   prdata = 32'(gimbal_reg);
            default:      prdata = '0;
        endcase
    end

    // --------------------------------------------------------- flow control
    // Global enable: the pipe moves unless the skid entry is occupied.
    logic ce;
    logic skid_valid_reg;
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    // --------------------------------------------------- input: sign / mag
    side_a_t in_side;
    logic    st0_valid_reg;
    side_a_t st0_reg;

    always_comb begin
        for (int k = 0; k < N_ENT; k++) begin
            in_side.neg[k] = s_tdata[DATA_W*k + DATA_W-1];
            in_side.mag[k] = in_side.neg[k] ? (~s_tdata[DATA_W*k +: DATA_W] + 32'd1)
                                            : s_tdata[DATA_W*k +: DATA_W];
        end
    end

    // squares
    logic              sq_valid_reg;
    side_a_t           sq_side_reg;
    logic [SQ_W-1:0]   sq_reg [N_ENT];

    // column sums
    logic              sum_valid_reg;
    side_a_t           sum_side_reg;
    logic [SQ_W-1:0]   sum_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else if (ce) begin
            st0_valid_reg <= s_tvalid;
            sq_valid_reg  <= st0_valid_reg;
            sum_valid_reg <= sq_valid_reg;
        end
        if (ce) begin
            st0_reg      <= in_side;
            sq_side_reg  <= st0_reg;
            sum_side_reg <= sq_side_reg;
            for (int k = 0; k < N_ENT; k++) begin
                sq_reg[k] <= {32'd0, st0_reg.mag[k]} * {32'd0, st0_reg.mag[k]};
            end
            for (int c = 0; c < LANES; c++) begin
                sum_reg[c] <= sq_reg[c] + sq_reg[3+c] + sq_reg[6+c];
            end
        end
    end

    // ------------------------------------------- column norms: 32 root cells
    localparam int NR_STEPS = SQ_W / 2;
    logic [SQ_W-1:0] nx [NR_STEPS+1][LANES];
    logic [SQ_W-1:0] nr [NR_STEPS+1][LANES];
    logic            nv [NR_STEPS+1];
    side_a_t         ns [NR_STEPS+1];

    always_comb begin
        nv[0] = sum_valid_reg;
        ns[0] = sum_side_reg;
        for (int l = 0; l < LANES; l++) begin
            nx[0][l] = sum_reg[l];
            nr[0][l] = '0;
        end
    end

    for (genvar k = 0; k < NR_STEPS; k++) begin : g_norm_root
        emt_sqrt_cell #(
            .W(SQ_W), .K(k), .LANES(LANES), .SW($bits(side_a_t))
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(nv[k]), .in_x(nx[k]), .in_r(nr[k]), .in_side(ns[k]),
            .out_valid(nv[k+1]), .out_x(nx[k+1]), .out_r(nr[k+1]), .out_side(ns[k+1])
        );
    end

    // ---------------------------------------- degenerate check, X products
    logic [NORM_W-1:0] norm [LANES];
    logic              degen;
    side_a_t           na;
    side_b_t           chk_next;

    always_comb begin
        na    = ns[NR_STEPS];
        degen = 1'b0;
        for (int c = 0; c < LANES; c++) begin
            norm[c] = nr[NR_STEPS][c][NORM_W-1:0];
            if (norm[c] == '0 || norm[c] < NORM_W'(min_norm_reg)) begin
                degen = 1'b1;
            end
        end
        chk_next.degen = degen;
        chk_next.neg   = na.neg;
        chk_next.mag0  = na.mag[0];
        chk_next.mag1  = na.mag[1];
        chk_next.mag3  = na.mag[3];
        chk_next.mag4  = na.mag[4];
        chk_next.p7    = {32'd0, na.mag[7]} * {32'd0, norm[2]};
        chk_next.p8    = {32'd0, na.mag[8]} * {32'd0, norm[1]};
    end

    logic              chk_valid_reg;
    side_b_t           chk_reg;
    logic [REM_W-1:0]  chk_rem_reg;
    logic [NORM_W-1:0] chk_div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_valid_reg <= 1'b0;
        end else if (ce) begin
            chk_valid_reg <= nv[NR_STEPS];
        end
        if (ce) begin
            chk_reg     <= chk_next;
            chk_rem_reg <= REM_W'(na.mag[6]) << (Q_W - 1);
            chk_div_reg <= norm[0];
        end
    end

    // ---------------------------- sine quotient |m20| / norm0: 31 divide cells
    logic [REM_W-1:0]  dr [Q_W+1];
    logic [NORM_W-1:0] dd [Q_W+1];
    logic [Q_W-1:0]    dq [Q_W+1];
    logic              dv [Q_W+1];
    side_b_t           ds [Q_W+1];

    assign dr[0] = chk_rem_reg;
    assign dd[0] = chk_div_reg;
    assign dq[0] = '0;
    assign dv[0] = chk_valid_reg;
    assign ds[0] = chk_reg;

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        emt_div_cell #(
            .RW(REM_W), .VW(NORM_W), .QW(Q_W), .J(Q_W - 1 - k), .SW($bits(side_b_t))
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(dv[k]), .in_rem(dr[k]), .in_div(dd[k]), .in_q(dq[k]), .in_side(ds[k]),
            .out_valid(dv[k+1]), .out_rem(dr[k+1]), .out_div(dd[k+1]), .out_q(dq[k+1]),
            .out_side(ds[k+1])
        );
    end

    // q^2, then 1 - q^2
    logic           qsq_valid_reg, t_valid_reg;
    side_c_t        qsq_side_reg, t_side_reg;
    logic [T_W-1:0] qsq_reg, t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qsq_valid_reg <= 1'b0;
            t_valid_reg   <= 1'b0;
        end else if (ce) begin
            qsq_valid_reg <= dv[Q_W];
            t_valid_reg   <= qsq_valid_reg;
        end
        if (ce) begin
            qsq_side_reg.b <= ds[Q_W];
            qsq_side_reg.q <= dq[Q_W];
            qsq_reg        <= T_W'(dq[Q_W]) * T_W'(dq[Q_W]);
            t_side_reg     <= qsq_side_reg;
            t_reg          <= (T_W'(1) << (2*(Q_W-1))) - qsq_reg;
        end
    end

    // ------------------------------------------- cosine root: 31 root cells
    localparam int CR_STEPS = T_W / 2;
    logic [T_W-1:0] cx [CR_STEPS+1][1];
    logic [T_W-1:0] cr [CR_STEPS+1][1];
    logic           cv [CR_STEPS+1];
    side_c_t        cs [CR_STEPS+1];

    always_comb begin
        cx[0][0] = t_reg;
        cr[0][0] = '0;
        cv[0]    = t_valid_reg;
        cs[0]    = t_side_reg;
    end

    for (genvar k = 0; k < CR_STEPS; k++) begin : g_cos_root
        emt_sqrt_cell #(
            .W(T_W), .K(k), .LANES(1), .SW($bits(side_c_t))
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(cv[k]), .in_x(cx[k]), .in_r(cr[k]), .in_side(cs[k]),
            .out_valid(cv[k+1]), .out_x(cx[k+1]), .out_r(cr[k+1]), .out_side(cs[k+1])
        );
    end

    // ------------------------------ gimbal decision and atan2 operand select
    // Lane 0: asin as atan2(+-q, c). Lane 1: X. Lane 2: Z.
    logic [C_W-1:0]   cosv;
    side_c_t          sc;
    side_d_t          sel_next;
    logic [MAG_W-1:0] sel_num [LANES];
    logic [MAG_W-1:0] sel_den [LANES];

    always_comb begin
        sc   = cs[CR_STEPS];
        cosv = cr[CR_STEPS][0][C_W-1:0];
        sel_next.degen  = sc.b.degen;
        sel_next.gimbal = (cosv >> 2) <= C_W'(gimbal_reg);

        sel_num[0] = MAG_W'(sc.q);
        sel_den[0] = MAG_W'(cosv);
        sel_next.num_neg[0] = !sc.b.neg[6] && (sc.q != '0);
        sel_next.den_neg[0] = 1'b0;

        if (sel_next.gimbal) begin
            sel_num[1] = MAG_W'(sc.b.mag1);
            sel_den[1] = MAG_W'(sc.b.mag4);
            sel_next.num_neg[1] = sc.b.neg[1];
            sel_next.den_neg[1] = sc.b.neg[4];
        end else begin
            sel_num[1] = sc.b.p7;
            sel_den[1] = sc.b.p8;
            sel_next.num_neg[1] = sc.b.neg[7];
            sel_next.den_neg[1] = sc.b.neg[8];
        end

        sel_num[2] = MAG_W'(sc.b.mag3);
        sel_den[2] = MAG_W'(sc.b.mag0);
        sel_next.num_neg[2] = sc.b.neg[3];
        sel_next.den_neg[2] = sc.b.neg[0];

        for (int l = 0; l < LANES; l++) begin
            // a zero magnitude carries no sign
            if (sel_num[l] == '0) begin
                sel_next.num_neg[l] = 1'b0;
            end
            sel_next.den_zero[l] = (sel_den[l] == '0);
        end
    end

    logic             sel_valid_reg;
    side_d_t          sel_reg;
    logic [MAG_W-1:0] sel_num_reg [LANES];
    logic [MAG_W-1:0] sel_den_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg <= 1'b0;
        end else if (ce) begin
            sel_valid_reg <= cv[CR_STEPS];
        end
        if (ce) begin
            sel_reg     <= sel_next;
            sel_num_reg <= sel_num;
            sel_den_reg <= sel_den;
        end
    end

    // ------------------------------ normalise into [2^39, 2^40): 6 shift cells
    logic [MAG_W-1:0] mn [NORM_STEPS+1][LANES];
    logic [MAG_W-1:0] md [NORM_STEPS+1][LANES];
    logic             mv [NORM_STEPS+1];
    side_d_t          ms [NORM_STEPS+1];

    assign mn[0] = sel_num_reg;
    assign md[0] = sel_den_reg;
    assign mv[0] = sel_valid_reg;
    assign ms[0] = sel_reg;

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        emt_norm_cell #(
            .MW(MAG_W), .S((1 << (NORM_STEPS - 1)) >> k), .LN(LANES), .SW($bits(side_d_t))
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(mv[k]), .in_num(mn[k]), .in_den(md[k]), .in_side(ms[k]),
            .out_valid(mv[k+1]), .out_num(mn[k+1]), .out_den(md[k+1]), .out_side(ms[k+1])
        );
    end

    // ------------------------ CORDIC start: half-turn for a negative x, and
    // the zero-x case resolved to +-pi/2 and passed through untouched.
    // Signs are judged after normalisation: an operand shifted down to zero
    // counts as non-negative there.
    side_d_t               sd;
    logic signed [A_W-1:0] pre_a [LANES];
    logic signed [A_W-1:0] pre_b [LANES];
    logic signed [Z_W-1:0] pre_z [LANES];
    logic signed [A_W-1:0] nmag;
    logic [LANES-1:0]      pre_nneg;
    logic [LANES-1:0]      pre_dneg;

    always_comb begin
        sd   = ms[NORM_STEPS];
        nmag = '0;
        for (int l = 0; l < LANES; l++) begin
            pre_nneg[l] = sd.num_neg[l] && (mn[NORM_STEPS][l] != '0);
            pre_dneg[l] = sd.den_neg[l] && (md[NORM_STEPS][l] != '0);
            pre_a[l] = A_W'(signed'({1'b0, md[NORM_STEPS][l][NORM_LO:0]}));
            nmag     = A_W'(signed'({1'b0, mn[NORM_STEPS][l][NORM_LO:0]}));
            pre_b[l] = (sd.num_neg[l] ^ pre_dneg[l]) ? -nmag : nmag;
            if (sd.den_zero[l]) begin
                pre_z[l] = sd.num_neg[l] ? -FX_HALF_PI : FX_HALF_PI;
            end else if (pre_dneg[l]) begin
                pre_z[l] = pre_nneg[l] ? -FX_PI : FX_PI;
            end else begin
                pre_z[l] = '0;
            end
        end
    end

    logic                  pre_valid_reg;
    side_e_t               pre_side_reg;
    logic signed [A_W-1:0] pre_a_reg [LANES];
    logic signed [A_W-1:0] pre_b_reg [LANES];
    logic signed [Z_W-1:0] pre_z_reg [LANES];
    logic [LANES-1:0]      pre_byp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (ce) begin
            pre_valid_reg <= mv[NORM_STEPS];
        end
        if (ce) begin
            pre_side_reg.degen  <= sd.degen;
            pre_side_reg.gimbal <= sd.gimbal;
            pre_a_reg           <= pre_a;
            pre_b_reg           <= pre_b;
            pre_z_reg           <= pre_z;
            pre_byp_reg         <= sd.den_zero;
        end
    end

    // ----------------------------------------- CORDIC: CORDIC_STEPS cells
    logic signed [A_W-1:0] ka [CORDIC_STEPS+1][LANES];
    logic signed [A_W-1:0] kb [CORDIC_STEPS+1][LANES];
    logic signed [Z_W-1:0] kz [CORDIC_STEPS+1][LANES];
    logic [LANES-1:0]      kbyp [CORDIC_STEPS+1];
    logic                  kv [CORDIC_STEPS+1];
    side_e_t               ks [CORDIC_STEPS+1];

    assign ka[0]   = pre_a_reg;
    assign kb[0]   = pre_b_reg;
    assign kz[0]   = pre_z_reg;
    assign kbyp[0] = pre_byp_reg;
    assign kv[0]   = pre_valid_reg;
    assign ks[0]   = pre_side_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        emt_cordic_cell #(
            .I(k), .LN(LANES), .SW($bits(side_e_t))
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(kv[k]), .in_a(ka[k]), .in_b(kb[k]), .in_z(kz[k]),
            .in_byp(kbyp[k]), .in_side(ks[k]),
            .out_valid(kv[k+1]), .out_a(ka[k+1]), .out_b(kb[k+1]), .out_z(kz[k+1]),
            .out_byp(kbyp[k+1]), .out_side(ks[k+1])
        );
    end

    // ------------------------------------------------- result and output
    // The final rotation is unused; only the angle leaves the chain.
    side_e_t               se;
    logic signed [Z_W-1:0] ang_x, ang_y, ang_z;
    logic [3*DATA_W-1:0]   res_data;
    logic                  res_ok;

    always_comb begin
        se    = ks[CORDIC_STEPS];
        ang_y = -kz[CORDIC_STEPS][0];
        ang_x = -kz[CORDIC_STEPS][1];
        ang_z = se.gimbal ? FX_PI : -kz[CORDIC_STEPS][2];
        if (se.degen) begin
            res_data = '0;
            res_ok   = 1'b0;
        end else begin
            res_data = {ang_z[DATA_W-1:0], ang_y[DATA_W-1:0], ang_x[DATA_W-1:0]};
            res_ok   = 1'b1;
        end
    end

    logic                out_valid_reg;
    logic [3*DATA_W-1:0] out_data_reg, skid_data_reg;
    logic                out_ok_reg, skid_ok_reg;
    logic                push, take;

    assign push = ce && kv[CORDIC_STEPS];
    assign take = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
        if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_ok_reg   <= skid_ok_reg;
            end else begin
                out_data_reg <= res_data;
                out_ok_reg   <= res_ok;
            end
        end else if (push) begin
            skid_data_reg <= res_data;
            skid_ok_reg   <= res_ok;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ok_reg;

`ifndef ASSERT_OFF
    // skid entry is only ever filled behind a held output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // a degenerate beat carries zero angles
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("degenerate beat with non-zero angles");

    // a held output beat with the skid entry busy stops the pipe
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid entry lost while stalled");

    // a min_column_norm write lands on that register
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && paddr[2] == REG_MIN_NORM) |=> (min_norm_reg == $past(pwdata[MINN_W-1:0])))
        else $error("min_column_norm write lost");
`endif

endmodule

@@ hdl/emt_sqrt_cell.sv @@
// One digit of a restoring square root, per lane.
module emt_sqrt_cell #(
    parameter int W     = 64,
    parameter int K     = 0,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [W-1:0]  in_x [LANES],
    input  logic [W-1:0]  in_r [LANES],
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [W-1:0]  out_x [LANES],
    output logic [W-1:0]  out_r [LANES],
    output logic [SW-1:0] out_side
);

    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2*K);

    logic          valid_reg;
    logic [W-1:0]  x_reg [LANES];
    logic [W-1:0]  x_next [LANES];
    logic [W-1:0]  r_reg [LANES];
    logic [W-1:0]  r_next [LANES];
    logic [W:0]    trial [LANES];
    logic [SW-1:0] side_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {1'b0, in_r[l]} + {1'b0, BIT};
            if ({1'b0, in_x[l]} >= trial[l]) begin
                x_next[l] = in_x[l] - trial[l][W-1:0];
                r_next[l] = (in_r[l] >> 1) + BIT;
            end else begin
                x_next[l] = in_x[l];
                r_next[l] = in_r[l] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
        if (ce) begin
            x_reg    <= x_next;
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;

endmodule

@@ hdl/emt_div_cell.sv @@
// One quotient bit of a restoring divider.
module emt_div_cell #(
    parameter int RW = 63,
    parameter int VW = 32,
    parameter int QW = 31,
    parameter int J  = 0,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [RW-1:0] in_rem,
    input  logic [VW-1:0] in_div,
    input  logic [QW-1:0] in_q,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [RW-1:0] out_rem,
    output logic [VW-1:0] out_div,
    output logic [QW-1:0] out_q,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [RW-1:0] rem_reg, rem_next, dsh;
    logic [VW-1:0] div_reg;
    logic [QW-1:0] q_reg, q_next;
    logic [SW-1:0] side_reg;

    always_comb begin
        dsh = RW'(in_div) << J;
        if (in_rem >= dsh) begin
            rem_next = in_rem - dsh;
            q_next   = in_q | (QW'(1) << J);
        end else begin
            rem_next = in_rem;
            q_next   = in_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
        if (ce) begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

@@ hdl/emt_norm_cell.sv @@
// One binary step of operand normalisation: shift both by S, right if the
// larger is at or above 2^(39+S), left if it is below 2^(40-S).
module emt_norm_cell
    import emt_pkg::*;
#(
    parameter int MW    = 64,
    parameter int S     = 1,
    parameter int LN    = 3,
    parameter int SW    = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [MW-1:0] in_num [LN],
    input  logic [MW-1:0] in_den [LN],
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [MW-1:0] out_num [LN],
    output logic [MW-1:0] out_den [LN],
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [MW-1:0] num_reg [LN];
    logic [MW-1:0] num_next [LN];
    logic [MW-1:0] den_reg [LN];
    logic [MW-1:0] den_next [LN];
    logic [MW-1:0] big [LN];
    logic [SW-1:0] side_reg;

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            big[l] = (in_num[l] > in_den[l]) ? in_num[l] : in_den[l];
            if ((big[l] >> (NORM_LO + S)) != '0) begin
                num_next[l] = in_num[l] >> S;
                den_next[l] = in_den[l] >> S;
            end else if ((big[l] >> (NORM_LO + 1 - S)) == '0) begin
                num_next[l] = in_num[l] << S;
                den_next[l] = in_den[l] << S;
            end else begin
                num_next[l] = in_num[l];
                den_next[l] = in_den[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
        if (ce) begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

@@ hdl/emt_cordic_cell.sv @@
// One vectoring CORDIC iteration per lane; bypassed lanes keep their angle.
module emt_cordic_cell
    import emt_pkg::*;
#(
    parameter int I  = 0,
    parameter int LN = 3,
    parameter int SW = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  in_valid,
    input  logic signed [A_W-1:0] in_a [LN],
    input  logic signed [A_W-1:0] in_b [LN],
    input  logic signed [Z_W-1:0] in_z [LN],
    input  logic [LN-1:0]         in_byp,
    input  logic [SW-1:0]         in_side,
    output logic                  out_valid,
    output logic signed [A_W-1:0] out_a [LN],
    output logic signed [A_W-1:0] out_b [LN],
    output logic signed [Z_W-1:0] out_z [LN],
    output logic [LN-1:0]         out_byp,
    output logic [SW-1:0]         out_side
);

    localparam logic signed [Z_W-1:0] ANG = atan_q28(I);

    logic                  valid_reg;
    logic signed [A_W-1:0] a_reg [LN];
    logic signed [A_W-1:0] a_next [LN];
    logic signed [A_W-1:0] b_reg [LN];
    logic signed [A_W-1:0] b_next [LN];
    logic signed [Z_W-1:0] z_reg [LN];
    logic signed [Z_W-1:0] z_next [LN];
    logic signed [A_W-1:0] as [LN];
    logic signed [A_W-1:0] bs [LN];
    logic [LN-1:0]         byp_reg;
    logic [SW-1:0]         side_reg;

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            as[l] = in_a[l] >>> I;
            bs[l] = in_b[l] >>> I;
            if (in_byp[l]) begin
                a_next[l] = in_a[l];
                b_next[l] = in_b[l];
                z_next[l] = in_z[l];
            end else if (!in_b[l][A_W-1]) begin
                a_next[l] = in_a[l] + bs[l];
                b_next[l] = in_b[l] - as[l];
                z_next[l] = in_z[l] + ANG;
            end else begin
                a_next[l] = in_a[l] - bs[l];
                b_next[l] = in_b[l] + as[l];
                z_next[l] = in_z[l] - ANG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
        if (ce) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            z_reg    <= z_next;
            byp_reg  <= in_byp;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_z     = z_reg;
    assign out_byp   = byp_reg;
    assign out_side  = side_reg;

endmodule
